// ===== hw/rtl/clns_pkg.sv =====
// Package for the character LCD nibble sequencer: word types, microcode
// types, program addresses and the microcode ROM. No dependencies.
package clns_pkg;

  // Input word
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic [5:0] message_length;
    logic       first_char;
  } in_word_t;

  // Output word: one timed bus step
  typedef struct packed {
    logic        reg_select;
    logic        strobe_res;
    logic [3:0]  nibble;
    logic [20:0] wait_us;
    logic        last_step;
  } out_word_t;

  // Command codes
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_INSTR = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_CHAR  = 2'd3;

  // Timing constants in microseconds
  localparam logic [20:0] PULSE_US    = 21'd100;
  localparam logic [20:0] POWERUP_US  = 21'd15000;
  localparam logic [20:0] SCROLL_US   = 21'd1000000;
  localparam logic [20:0] PREROLL_US  = 21'd2000000;

  // Scroll cap, keeps one word at or under 64 steps
  localparam int unsigned MAX_SCROLLS = 28;
  localparam int unsigned CNT_W       = 5;

  // Program addresses
  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] A_INIT     = 5'd0;
  localparam logic [PC_W-1:0] A_CLEAR    = 5'd15;
  localparam logic [PC_W-1:0] A_LINE     = 5'd19;
  localparam logic [PC_W-1:0] A_CHAR     = 5'd21;
  localparam logic [PC_W-1:0] A_SHIFT_HI = 5'd24;
  localparam logic [PC_W-1:0] A_LAST     = 5'd26;

  // Step kind: what drives the bus
  typedef enum logic [1:0] {
    K_PAUSE,   // wait only
    K_INSTR,   // enable pulse, constant nibble, instruction register
    K_VAL_HI,  // enable pulse, upper nibble of the latched byte
    K_VAL_LO   // enable pulse, lower nibble of the latched byte
  } kind_e;

  // Sequencing of the step counter
  typedef enum logic [2:0] {
    SEQ_NEXT,    // fall through
    SEQ_END,     // final step
    SEQ_LINE,    // to line jump or to the character
    SEQ_SCROLL,  // into the scroll tail or end
    SEQ_LOOP     // repeat the shift while the count lasts
  } seq_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  nib;
    logic [20:0] wait_us;
    seq_e        seq;
  } ucode_t;

  // Microcode ROM
  function automatic ucode_t clns_ucode(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{kind: K_PAUSE, nib: 4'h0, wait_us: SCROLL_US, seq: SEQ_END};
    case (addr)
      // power-up initialization
      5'd0:  w = '{K_PAUSE, 4'h0, POWERUP_US,           SEQ_NEXT};
      5'd1:  w = '{K_INSTR, 4'h3, PULSE_US + 21'd4100,  SEQ_NEXT};
      5'd2:  w = '{K_INSTR, 4'h3, PULSE_US + 21'd200,   SEQ_NEXT};
      5'd3:  w = '{K_INSTR, 4'h3, PULSE_US + 21'd70,    SEQ_NEXT};
      5'd4:  w = '{K_INSTR, 4'h2, PULSE_US + 21'd70,    SEQ_NEXT};
      5'd5:  w = '{K_INSTR, 4'h2, PULSE_US,             SEQ_NEXT};
      5'd6:  w = '{K_INSTR, 4'h8, PULSE_US + 21'd70,    SEQ_NEXT};
      5'd7:  w = '{K_INSTR, 4'h0, PULSE_US,             SEQ_NEXT};
      5'd8:  w = '{K_INSTR, 4'hE, PULSE_US + 21'd70,    SEQ_NEXT};
      5'd9:  w = '{K_INSTR, 4'h0, PULSE_US,             SEQ_NEXT};
      5'd10: w = '{K_INSTR, 4'h1, PULSE_US + 21'd2000,  SEQ_NEXT};
      5'd11: w = '{K_INSTR, 4'h0, PULSE_US,             SEQ_NEXT};
      5'd12: w = '{K_INSTR, 4'h6, PULSE_US,             SEQ_NEXT};
      5'd13: w = '{K_INSTR, 4'h0, PULSE_US,             SEQ_NEXT};
      5'd14: w = '{K_INSTR, 4'h1, PULSE_US + 21'd3000,  SEQ_END};
      // first character: clear, then home
      5'd15: w = '{K_INSTR, 4'h0, PULSE_US,             SEQ_NEXT};
      5'd16: w = '{K_INSTR, 4'h1, PULSE_US + 21'd3000,  SEQ_NEXT};
      5'd17: w = '{K_INSTR, 4'h0, PULSE_US,             SEQ_NEXT};
      5'd18: w = '{K_INSTR, 4'h2, PULSE_US + 21'd1640,  SEQ_LINE};
      // second line, DDRAM 0x40
      5'd19: w = '{K_INSTR, 4'hC, PULSE_US,             SEQ_NEXT};
      5'd20: w = '{K_INSTR, 4'h0, PULSE_US + 21'd40,    SEQ_NEXT};
      // the byte itself, shared by raw writes and characters
      5'd21: w = '{K_VAL_HI, 4'h0, PULSE_US,            SEQ_NEXT};
      5'd22: w = '{K_VAL_LO, 4'h0, PULSE_US,            SEQ_SCROLL};
      // scroll tail
      5'd23: w = '{K_PAUSE, 4'h0, PREROLL_US,           SEQ_NEXT};
      5'd24: w = '{K_INSTR, 4'h1, PULSE_US,             SEQ_NEXT};
      5'd25: w = '{K_INSTR, 4'h8, PULSE_US + SCROLL_US, SEQ_LOOP};
      5'd26: w = '{K_PAUSE, 4'h0, SCROLL_US,            SEQ_END};
      default: w = '{K_PAUSE, 4'h0, SCROLL_US,          SEQ_END};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_sequencer_core.sv =====
// Top level of the character LCD nibble sequencer: a microcode ROM stepped
// by a program counter drives the bus step datapath. Depends on clns_pkg.
//
// The word is taken into the program counter and payload registers; its first bus step
// then goes through the output register, and one step leaves per cycle while the output
// side takes them. A new word is taken only once the last step of the current one has
// been emitted, set by the single program counter. Reset clears busy, the output register
// valid and the character position; no clearing pass.
module char_lcd_nibble_sequencer_core
  import clns_pkg::*;
#(
  parameter int unsigned LINE_CHARS    = 8,
  parameter int unsigned VISIBLE_CHARS = 16,
  parameter int unsigned MAX_MESSAGE   = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam logic [6:0] LineW = 7'(LINE_CHARS);
  localparam logic [6:0] VisW  = 7'(VISIBLE_CHARS);
  localparam logic [5:0] MaxW  = 6'(MAX_MESSAGE);
  localparam logic [6:0] CapW  = 7'(MAX_SCROLLS);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            line_q, scroll_q, rs_q;
  logic [7:0]      val_q;
  logic [5:0]      pos_q;
  logic            out_valid_q;
  out_word_t       out_q;

  logic            in_acc, emit;
  ucode_t          uw;
  out_word_t       step;
  logic            last_c;

  // Entry decode
  logic [5:0]      len_c, pos_c;
  logic [6:0]      diff_c;
  logic            line_c, scroll_c;
  logic [PC_W-1:0] entry_c;
  logic [CNT_W-1:0] n_c;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign emit       = busy_q && (!out_valid_q || out_ready_i);

  // Clamp length, resolve position and the branch flags for a character
  always_comb begin
    if (in_data_i.message_length == 6'd0) begin
      len_c = 6'd1;
    end else if (in_data_i.message_length > MaxW) begin
      len_c = MaxW;
    end else begin
      len_c = in_data_i.message_length;
    end
    pos_c    = in_data_i.first_char ? 6'd0 : pos_q;
    line_c   = ({1'b0, pos_c} == LineW) && ({1'b0, len_c} > LineW);
    scroll_c = ({1'b0, pos_c} + 7'd1 == {1'b0, len_c}) && ({1'b0, len_c} > VisW);
    diff_c   = {1'b0, len_c} - VisW;
    n_c      = (diff_c > CapW) ? CNT_W'(MAX_SCROLLS) : diff_c[CNT_W-1:0];
    case (in_data_i.command)
      CMD_INIT:  entry_c = A_INIT;
      CMD_INSTR: entry_c = A_CHAR;
      CMD_DATA:  entry_c = A_CHAR;
      CMD_CHAR: begin
        if (in_data_i.first_char) begin
          entry_c = A_CLEAR;
        end else if (line_c) begin
          entry_c = A_LINE;
        end else begin
          entry_c = A_CHAR;
        end
      end
      default: entry_c = A_INIT;
    endcase
  end

  // Datapath: one bus step from the current control word
  assign uw = clns_ucode(pc_q);

  always_comb begin
    step = '0;
    step.wait_us = uw.wait_us;
    case (uw.kind)
      K_PAUSE: begin
        step.strobe_res = 1'b0;
      end
      K_INSTR: begin
        step.strobe_res = 1'b1;
        step.nibble     = uw.nib;
      end
      K_VAL_HI: begin
        step.strobe_res = 1'b1;
        step.reg_select = rs_q;
        step.nibble     = val_q[7:4];
      end
      K_VAL_LO: begin
        step.strobe_res = 1'b1;
        step.reg_select = rs_q;
        step.nibble     = val_q[3:0];
      end
      default: step.strobe_res = 1'b0;
    endcase
    step.last_step = last_c;
  end

  // Sequencer: next address, loop count, end of program
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    cnt_d  = cnt_q;
    last_c = 1'b0;
    case (uw.seq)
      SEQ_NEXT: pc_d = pc_q + 1'b1;
      SEQ_END: begin
        last_c = 1'b1;
        busy_d = 1'b0;
      end
      SEQ_LINE: pc_d = line_q ? A_LINE : A_CHAR;
      SEQ_SCROLL: begin
        if (scroll_q) begin
          pc_d = pc_q + 1'b1;
        end else begin
          last_c = 1'b1;
          busy_d = 1'b0;
        end
      end
      SEQ_LOOP: begin
        if (cnt_q > CNT_W'(1)) begin
          cnt_d = cnt_q - 1'b1;
          pc_d  = A_SHIFT_HI;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      default: begin
        last_c = 1'b1;
        busy_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= A_INIT;
      out_valid_q <= 1'b0;
      pos_q       <= 6'd0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        pc_q   <= entry_c;
        if (in_data_i.command == CMD_CHAR) begin
          pos_q <= (pos_c == 6'd63) ? pos_c : pos_c + 6'd1;
        end
      end else if (emit) begin
        busy_q <= busy_d;
        pc_q   <= pc_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q    <= in_data_i.byte_value;
      rs_q     <= in_data_i.command[1];
      line_q   <= (in_data_i.command == CMD_CHAR) && line_c;
      scroll_q <= (in_data_i.command == CMD_CHAR) && scroll_c;
      cnt_q    <= n_c;
    end else if (emit) begin
      cnt_q <= cnt_d;
    end
    if (emit) begin
      out_q <= step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q)
    else $error("word accepted but sequencer not busy");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= A_LAST))
    else $error("program counter out of program");

  a_loop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pc_q == A_SHIFT_HI) |-> (cnt_q != '0))
    else $error("scroll loop entered with zero count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output word changed while stalled");

endmodule

// ===== tb/char_lcd_nibble_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for char_lcd_nibble_sequencer_core: a bus-step predictor
// and scoreboard class, random idling on both handshakes. Depends on clns_pkg.
module char_lcd_nibble_sequencer_core_tb
  import clns_pkg::*;
();

  localparam int unsigned LINE_CHARS     = 8;
  localparam int unsigned VISIBLE_CHARS  = 16;
  localparam int unsigned MAX_MESSAGE    = 40;
  localparam int unsigned SHIFT_CAP      = 28;
  localparam int unsigned RANDOM_WORDS   = 156;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 20;

  // LCD instruction bytes
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_HOME       = 8'h02;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0E;
  localparam logic [7:0] LCD_SHIFT_LEFT = 8'h18;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0] LCD_LINE2      = 8'hC0;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // Predicts the bus steps of each accepted word and checks them in order
  class lcd_step_board;
    out_word_t   pending_steps[$];
    int          char_pos;
    int unsigned mismatches;
    int unsigned steps_seen;
    int unsigned words_seen;

    function new();
      char_pos   = 0;
      mismatches = 0;
      steps_seen = 0;
      words_seen = 0;
    endfunction

    function void push_step(logic rs, logic strobe, logic [3:0] nib, int unsigned wait_val);
      out_word_t s;
      s.reg_select = rs;
      s.strobe_res = strobe;
      s.nibble     = nib;
      s.wait_us    = 21'(wait_val);
      s.last_step  = 1'b0;
      pending_steps.push_back(s);
    endfunction

    // every enable pulse carries a 100 us hold plus any extra pause
    function void push_nib(logic rs, logic [3:0] nib, int unsigned extra);
      push_step(rs, 1'b1, nib, 100 + extra);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, int unsigned extra);
      push_nib(rs, b[7:4], 0);
      push_nib(rs, b[3:0], extra);
    endfunction

    function void take_word(in_word_t w);
      int unsigned len;
      int unsigned pos;
      int unsigned n_shift;
      int unsigned before_cnt;
      before_cnt = pending_steps.size();
      words_seen++;
      case (w.command)
        CMD_INIT: begin
          push_step(RS_INSTR, 1'b0, 4'h0, 15000);
          push_nib(RS_INSTR, 4'h3, 4100);
          push_nib(RS_INSTR, 4'h3, 200);
          push_nib(RS_INSTR, 4'h3, 70);
          push_nib(RS_INSTR, 4'h2, 70);
          push_byte(RS_INSTR, LCD_FUNC_SET, 70);
          push_byte(RS_INSTR, LCD_DISPLAY_ON, 70);
          push_byte(RS_INSTR, LCD_CLEAR, 2000);
          push_byte(RS_INSTR, LCD_ENTRY_MODE, 0);
          push_byte(RS_INSTR, LCD_CLEAR, 3000);
        end
        CMD_INSTR: push_byte(RS_INSTR, w.byte_value, 0);
        CMD_DATA:  push_byte(RS_DATA, w.byte_value, 0);
        default: begin
          // length 0 counts as 1, long lengths saturate
          len = w.message_length;
          if (len == 0) len = 1;
          if (len > MAX_MESSAGE) len = MAX_MESSAGE;
          if (w.first_char) begin
            char_pos = 0;
            push_byte(RS_INSTR, LCD_CLEAR, 3000);
            push_byte(RS_INSTR, LCD_HOME, 1640);
          end
          pos = char_pos;
          if (pos == LINE_CHARS && len > LINE_CHARS) push_byte(RS_INSTR, LCD_LINE2, 40);
          push_byte(RS_DATA, w.byte_value, 0);
          // scroll tail after the last character of a long message
          if (pos + 1 == len && len > VISIBLE_CHARS) begin
            n_shift = len - VISIBLE_CHARS;
            if (n_shift > SHIFT_CAP) n_shift = SHIFT_CAP;
            push_step(RS_INSTR, 1'b0, 4'h0, 2000000);
            repeat (n_shift) push_byte(RS_INSTR, LCD_SHIFT_LEFT, 1000000);
            push_step(RS_INSTR, 1'b0, 4'h0, 1000000);
          end
          if (pos < 63) char_pos = pos + 1;
        end
      endcase
      if (pending_steps.size() > before_cnt)
        pending_steps[pending_steps.size() - 1].last_step = 1'b1;
    endfunction

    function void check_step(out_word_t got);
      out_word_t want;
      steps_seen++;
      if (pending_steps.size() == 0) begin
        $error("bus step with no expectation pending: %h", got);
        mismatches++;
        return;
      end
      want = pending_steps.pop_front();
      if (got.reg_select !== want.reg_select) begin
        $error("reg_select: expected %0d, actual %0d", want.reg_select, got.reg_select);
        mismatches++;
      end
      if (got.strobe_res !== want.strobe_res) begin
        $error("strobe_res: expected %0d, actual %0d", want.strobe_res, got.strobe_res);
        mismatches++;
      end
      if (got.nibble !== want.nibble) begin
        $error("nibble: expected %h, actual %h", want.nibble, got.nibble);
        mismatches++;
      end
      if (got.wait_us !== want.wait_us) begin
        $error("wait_us: expected %0d, actual %0d", want.wait_us, got.wait_us);
        mismatches++;
      end
      if (got.last_step !== want.last_step) begin
        $error("last_step: expected %0d, actual %0d", want.last_step, got.last_step);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  lcd_step_board board;
  bit          tx_free;
  bit          rx_free;
  int unsigned hold_reqs;
  int unsigned words_sent;
  int unsigned chars_sent;
  int unsigned stall_cycles;

  char_lcd_nibble_sequencer_core #(
    .LINE_CHARS   (LINE_CHARS),
    .VISIBLE_CHARS(VISIBLE_CHARS),
    .MAX_MESSAGE  (MAX_MESSAGE)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Handshake monitor: note words first, then check steps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.take_word(in_data_i);
      if (out_valid_o && out_ready_i) board.check_step(out_data_o);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_nibble_sequencer_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Output side: random stalls, plus one long hold on request
  initial begin : receiver
    int unsigned holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!rx_free && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_gap()) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] val, logic [5:0] len,
                                         logic first);
    in_word_t w;
    w.command        = cmd;
    w.byte_value     = val;
    w.message_length = len;
    w.first_char     = first;
    return w;
  endfunction

  // Offer one word, hold it until taken, then maybe idle
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (w.command == CMD_CHAR) chars_sent++;
    gap = (tx_free || $urandom_range(0, 1) == 0) ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Characters of one message; count may differ from the length for broken runs
  task automatic send_message(input logic [5:0] len, input int unsigned count,
                              input logic with_first);
    for (int unsigned i = 0; i < count; i++)
      send_word(make_word(CMD_CHAR, 8'($urandom_range(0, 255)), len,
                          (i == 0) ? with_first : 1'b0));
  endtask

  // Stop offering, then wait until every expected step has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_steps.size() != 0);
  endtask

  initial begin : main
    int unsigned rand_words;
    int unsigned kind;
    int unsigned eff_len;
    int unsigned count;
    bit          pressed;
    bit          overran;
    bit          paused;
    logic [5:0]  len;
    board         = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    tx_free       = 1'b1;
    rx_free       = 1'b1;
    hold_reqs     = 0;
    words_sent    = 0;
    chars_sent    = 0;
    rand_words    = 0;
    pressed       = 1'b0;
    overran       = 1'b0;
    paused        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: init, raw byte extremes, odd lengths, one scrolling message
    send_word(make_word(CMD_INIT, 8'h00, 6'd0, 1'b0));
    send_word(make_word(CMD_INSTR, 8'h00, 6'd0, 1'b0));
    send_word(make_word(CMD_INSTR, 8'hFF, 6'd63, 1'b1));
    send_word(make_word(CMD_DATA, 8'h00, 6'd0, 1'b0));
    send_word(make_word(CMD_DATA, 8'hFF, 6'd63, 1'b1));
    send_word(make_word(CMD_CHAR, 8'h41, 6'd0, 1'b1));
    send_word(make_word(CMD_CHAR, 8'hFF, 6'd63, 1'b1));
    tx_free = 1'b0;
    rx_free = 1'b0;
    send_message(6'd17, 17, 1'b1);
    wait_drained();

    // Random: mostly well-formed messages, some raw words, init and noise
    while (rand_words < RANDOM_WORDS) begin
      tx_free = ($urandom_range(0, 5) == 0);
      rx_free = ($urandom_range(0, 5) == 0);
      if (!pressed && rand_words >= 30) begin
        // receiver stalls long while the sender keeps offering characters
        pressed = 1'b1;
        hold_reqs++;
        send_message(6'd20, 20, 1'b1);
        rand_words += 20;
      end else if (!overran && rand_words >= 90) begin
        // run far past the end so the position saturates
        overran = 1'b1;
        send_message(6'($urandom_range(1, 40)), 66, 1'b1);
        rand_words += 66;
      end else if (!paused && rand_words >= 60) begin
        paused = 1'b1;
        wait_drained();
      end else begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          case ($urandom_range(0, 7))
            0:       len = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(41, 63));
            1, 2, 3: len = 6'($urandom_range(17, 40));
            default: len = 6'($urandom_range(1, 16));
          endcase
          eff_len = (len == 0) ? 1 : (len > MAX_MESSAGE) ? MAX_MESSAGE : len;
          case ($urandom_range(0, 5))
            0:       count = $urandom_range(1, eff_len);
            1:       count = eff_len + $urandom_range(1, 3);
            default: count = eff_len;
          endcase
          send_message(len, count, $urandom_range(0, 9) != 0);
          rand_words += count;
        end else if (kind <= 7) begin
          send_word(make_word((kind == 6) ? CMD_INSTR : CMD_DATA,
                              8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                              1'($urandom_range(0, 1))));
          rand_words++;
        end else if (kind == 8) begin
          send_word(make_word(CMD_INIT, 8'($urandom_range(0, 255)),
                              6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
          rand_words++;
        end else begin
          send_word(in_word_t'($urandom));
          rand_words++;
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then give stray steps a chance to show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.pending_steps.size() != 0) begin
      $error("%0d expected bus steps never arrived", board.pending_steps.size());
      board.mismatches++;
    end

    $display("Run: %0d words sent (%0d message characters), %0d bus steps checked,",
             words_sent, chars_sent, board.steps_seen);
    $display("including init, raw bytes, line jumps, scroll tails and position overrun.");
    if (board.mismatches == 0) begin
      $display("char_lcd_nibble_sequencer_core verification clean");
    end else begin
      $display("char_lcd_nibble_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
